FILE: src/penalty_contact_force_with_damping_top_defines.svh
// Assertion macros shared by the RTL. Every macro expects clk and arst_n in scope.
`ifndef PENALTY_CONTACT_FORCE_WITH_DAMPING_TOP_DEFINES_SVH
`define PENALTY_CONTACT_FORCE_WITH_DAMPING_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCFD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcfd assertion failed");

`endif

FILE: src/pcfd_pkg.sv
`default_nettype none
package pcfd_pkg;

	localparam int PARTICLE_COUNT_DEF = 4096;
	localparam int FRACTION_BITS_DEF  = 16;

	localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	// Configuration register indexes.
	localparam logic [0:0] REG_NORMAL_STIFFNESS  = 1'b0;
	localparam logic [0:0] REG_TANGENT_STIFFNESS = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_AREA,
		ST_KN,
		ST_FN,
		ST_FNORM,
		ST_KT,
		ST_DAMPN,
		ST_NL,
		ST_RPROJ,
		ST_CTF,
		ST_DAMPT,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [63:0]      a;
		logic signed [63:0]      b;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [63:0]      y;
	} mul_rsp_t;

	typedef struct packed {
		logic [31:0]             tag;
		logic [31:0]             last_pen;
		logic [2:0][31:0]        anchor;
		logic [2:0][31:0]        last_tf;
	} entry_t;

	// Add with saturation to the symmetric 64-bit range.
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(SAT_MAX)) begin
			return SAT_MAX;
		end else if (s < -65'(SAT_MAX)) begin
			return -SAT_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: src/pcfd_mulq.sv
`default_nettype none
module pcfd_mulq #(
	parameter int FRACTION_BITS = pcfd_pkg::FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pcfd_pkg::mul_req_t req,
	output pcfd_pkg::mul_rsp_t     rsp
);
	import pcfd_pkg::*;

	localparam logic [127:0] RND = 128'(1) << (FRACTION_BITS - 1);

	logic [63:0]        ua_q, ub_q, pp_q;
	logic               neg_q, run_q, done_q;
	logic [2:0]         step_q;
	logic [1:0]         sh_q;
	logic [127:0]       acc_q, sum, pp_ext;
	logic [63:0]        rl, rmag;
	logic signed [63:0] y_q;
	logic               sat;

	// Rounding of the magnitude at the binary point, then saturation.
	always_comb begin
		sum  = acc_q + RND;
		rl   = sum[FRACTION_BITS +: 64];
		sat  = ((sum >> (FRACTION_BITS + 64)) != 128'd0) || rl[63];
		rmag = sat ? 64'(SAT_MAX) : rl;
		case (sh_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd3:    pp_ext = {pp_q, 64'd0};
			default: pp_ext = {32'd0, pp_q, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= 3'd0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
			ub_q  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			acc_q <= 128'd0;
		end else if (run_q) begin
			if (step_q <= 3'd3) begin
				case (step_q[1:0])
					2'd0:    pp_q <= ua_q[31:0]  * ub_q[31:0];
					2'd1:    pp_q <= ua_q[31:0]  * ub_q[63:32];
					2'd2:    pp_q <= ua_q[63:32] * ub_q[31:0];
					default: pp_q <= ua_q[63:32] * ub_q[63:32];
				endcase
				sh_q <= step_q[1:0];
			end
			if (step_q >= 3'd1 && step_q <= 3'd4) begin
				acc_q <= acc_q + pp_ext;
			end
			if (step_q == 3'd5) begin
				y_q <= neg_q ? -$signed(rmag) : $signed(rmag);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.y    = y_q;

endmodule
`default_nettype wire

FILE: src/penalty_contact_force_with_damping_top.sv
`default_nettype none
// Channel   | Signals                                           | Direction
// ----------+---------------------------------------------------+----------
// item      | start, busy, substep .. particle_length           | in
// result    | done, force_x, force_y, force_z                   | out
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data         | in
//
// An item transfers when start is high and busy is low. Its result appears
// on the force ports with done high for one cycle. The time an item takes is
// set by the single shared multiplier, which works through the 6 products of
// a fresh contact or the 22 of a continuing one in turn, plus the states that
// fold the particle index onto the table and the state that writes the entry
// back. After reset the table is cleared one entry per cycle with busy high;
// config writes are always taken. The receiver cannot stall a result.
`include "penalty_contact_force_with_damping_top_defines.svh"
module penalty_contact_force_with_damping_top #(
	parameter int PARTICLE_COUNT = pcfd_pkg::PARTICLE_COUNT_DEF,
	parameter int FRACTION_BITS  = pcfd_pkg::FRACTION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [31:0]        substep,
	input  wire logic [11:0]        particle_index,
	input  wire logic signed [31:0] penetration,
	input  wire logic signed [17:0] normal_x,
	input  wire logic signed [17:0] normal_y,
	input  wire logic signed [17:0] normal_z,
	input  wire logic signed [31:0] contact_x,
	input  wire logic signed [31:0] contact_y,
	input  wire logic signed [31:0] contact_z,
	input  wire logic [30:0]        particle_length,
	output logic                    done,
	output logic signed [31:0]      force_x,
	output logic signed [31:0]      force_y,
	output logic signed [31:0]      force_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import pcfd_pkg::*;

	localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
	localparam logic [AW-1:0] LAST_ENTRY = AW'(PARTICLE_COUNT - 1);
	// Damping factor 0.02 in the working fixed-point format.
	localparam logic signed [63:0] DAMP_Q = 64'(((64'sd1 <<< FRACTION_BITS) + 25) / 50);
	// Rounded-up reciprocal of the table size; with 32 fraction bits the
	// quotient is exact for every 12-bit index.
	localparam logic [32:0] RECIP =
		33'(((64'd1 << 32) + 64'(PARTICLE_COUNT) - 64'd1) / 64'(PARTICLE_COUNT));

	state_t state_q, state_d;
	logic   wait_q, done_q;
	logic [1:0] comp_q;
	logic [AW-1:0] clr_cnt_q, addr_q;
	logic [11:0] quot_q;
	logic [44:0] quot_prod;
	logic [31:0] fold_prod, fold_rem;

	logic [31:0] nstiff_q, tstiff_q;

	// Captured item.
	logic [31:0]        sub_q;
	logic [11:0]        pidx_q;
	logic signed [31:0] pen_q;
	logic signed [17:0] n_q [3];
	logic signed [31:0] c_q [3];
	logic [30:0]        len_q;

	// Working registers.
	logic signed [63:0] area_q, tmp_q, fn_q, kta_q, nl_q;
	logic signed [63:0] f_q [3];
	logic signed [63:0] r_q [3];
	logic signed [31:0] ctf_q [3];
	logic signed [31:0] fo_q [3];

	// Per-particle table: tag, last penetration, anchor, last tangential force.
	entry_t mem [PARTICLE_COUNT];
	entry_t rdata_q, wdata;
	logic   mem_we;
	logic [AW-1:0] waddr;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	logic cont, is_vec, last_comp;
	logic signed [1:0] s_pen, s_tf;
	logic signed [63:0] y_signed_pen, y_signed_tf, ctf_ext;

	pcfd_mulq #(.FRACTION_BITS(FRACTION_BITS)) u_mulq (
		.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp)
	);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign force_x   = fo_q[0];
	assign force_y   = fo_q[1];
	assign force_z   = fo_q[2];

	// A continuing contact carries a tag equal to the current substep.
	assign cont = (rdata_q.tag == sub_q);

	// The particle index modulo the table size: quotient by reciprocal
	// multiplication, then the remainder by one multiply and subtract.
	assign quot_prod = {33'd0, pidx_q} * {12'd0, RECIP};
	assign fold_prod = {20'd0, quot_q} * 32'(PARTICLE_COUNT);
	assign fold_rem  = {20'd0, pidx_q} - fold_prod;

	// Sign of the penetration change and of the tangential force change.
	always_comb begin
		if (pen_q > $signed(rdata_q.last_pen)) begin
			s_pen = 2'sd1;
		end else if (pen_q < $signed(rdata_q.last_pen)) begin
			s_pen = -2'sd1;
		end else begin
			s_pen = 2'sd0;
		end
		if (ctf_q[comp_q] > $signed(rdata_q.last_tf[comp_q])) begin
			s_tf = 2'sd1;
		end else if (ctf_q[comp_q] < $signed(rdata_q.last_tf[comp_q])) begin
			s_tf = -2'sd1;
		end else begin
			s_tf = 2'sd0;
		end
		// Normal damping opposes the change, tangential damping follows it.
		y_signed_pen = (s_pen > 0) ? -mrsp.y : ((s_pen < 0) ? mrsp.y : 64'sd0);
		y_signed_tf  = (s_tf > 0) ? mrsp.y : ((s_tf < 0) ? -mrsp.y : 64'sd0);
		ctf_ext      = 64'(ctf_q[comp_q]);
	end

	// Next state and multiplier operands.
	always_comb begin
		state_d    = state_q;
		mreq.start = 1'b0;
		mreq.a     = 64'sd0;
		mreq.b     = 64'sd0;
		is_vec     = 1'b0;
		case (state_q)
			ST_FNORM, ST_DAMPN, ST_NL, ST_RPROJ, ST_CTF, ST_DAMPT: is_vec = 1'b1;
			default: is_vec = 1'b0;
		endcase
		last_comp = !is_vec || (comp_q == 2'd2);
		case (state_q)
			ST_AREA: begin
				mreq.a = $signed({33'd0, len_q});
				mreq.b = $signed({33'd0, len_q});
			end
			ST_KN: begin
				mreq.a = $signed({32'd0, nstiff_q});
				mreq.b = area_q;
			end
			ST_FN: begin
				mreq.a = tmp_q;
				mreq.b = 64'(pen_q);
			end
			ST_FNORM: begin
				mreq.a = fn_q;
				mreq.b = 64'(n_q[comp_q]);
			end
			ST_KT: begin
				mreq.a = $signed({32'd0, tstiff_q});
				mreq.b = area_q;
			end
			ST_DAMPN: begin
				mreq.a = f_q[comp_q][63] ? -f_q[comp_q] : f_q[comp_q];
				mreq.b = DAMP_Q;
			end
			ST_NL: begin
				mreq.a = r_q[comp_q];
				mreq.b = 64'(n_q[comp_q]);
			end
			ST_RPROJ: begin
				mreq.a = nl_q;
				mreq.b = 64'(n_q[comp_q]);
			end
			ST_CTF: begin
				mreq.a = r_q[comp_q];
				mreq.b = kta_q;
			end
			ST_DAMPT: begin
				mreq.a = ctf_ext[63] ? -ctf_ext : ctf_ext;
				mreq.b = DAMP_Q;
			end
			default: begin
				mreq.a = 64'sd0;
				mreq.b = 64'sd0;
			end
		endcase
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ENTRY) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: state_d = ST_READ;
			ST_READ: state_d = ST_AREA;
			ST_WRITE: state_d = ST_IDLE;
			default: begin
				mreq.start = !wait_q;
				if (wait_q && mrsp.done && last_comp) begin
					case (state_q)
						ST_AREA:  state_d = ST_KN;
						ST_KN:    state_d = ST_FN;
						ST_FN:    state_d = ST_FNORM;
						ST_FNORM: state_d = cont ? ST_KT : ST_WRITE;
						ST_KT:    state_d = ST_DAMPN;
						ST_DAMPN: state_d = ST_NL;
						ST_NL:    state_d = ST_RPROJ;
						ST_RPROJ: state_d = ST_CTF;
						ST_CTF:   state_d = ST_DAMPT;
						default:  state_d = ST_WRITE;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer control and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q    <= 1'b0;
			comp_q    <= 2'd0;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
			nstiff_q  <= 32'd0;
			tstiff_q  <= 32'd0;
		end else begin
			done_q <= (state_q == ST_WRITE);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NORMAL_STIFFNESS:  nstiff_q <= cfg_data;
					REG_TANGENT_STIFFNESS: tstiff_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (mreq.start) begin
				wait_q <= 1'b1;
			end else if (wait_q && mrsp.done) begin
				wait_q <= 1'b0;
				comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
			end
		end
	end

	// Datapath captures.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sub_q  <= substep;
					pidx_q <= particle_index;
					pen_q  <= penetration;
					n_q[0] <= normal_x;
					n_q[1] <= normal_y;
					n_q[2] <= normal_z;
					c_q[0] <= contact_x;
					c_q[1] <= contact_y;
					c_q[2] <= contact_z;
					len_q  <= particle_length;
				end
			end
			ST_MOD: quot_q <= quot_prod[43:32];
			ST_READ: addr_q <= AW'(fold_rem);
			default: ;
		endcase
		// The entry is read as the first product starts, from the address registered in ST_READ.
		if (state_q == ST_AREA && mreq.start) begin
			rdata_q <= mem[addr_q];
		end
		if (mrsp.done && wait_q) begin
			case (state_q)
				ST_AREA:  area_q <= mrsp.y;
				ST_KN:    tmp_q  <= mrsp.y;
				ST_FN:    fn_q   <= mrsp.y;
				ST_FNORM: f_q[comp_q] <= mrsp.y;
				ST_KT:    kta_q  <= mrsp.y;
				ST_DAMPN: f_q[comp_q] <= sat_add(f_q[comp_q], y_signed_pen);
				ST_NL:    nl_q   <= sat_add(nl_q, mrsp.y);
				ST_RPROJ: r_q[comp_q] <= sat_add(r_q[comp_q], -mrsp.y);
				ST_CTF:   ctf_q[comp_q] <= sat32(mrsp.y);
				ST_DAMPT: f_q[comp_q] <= sat_add(f_q[comp_q], y_signed_tf);
				default: ;
			endcase
		end
		if (mreq.start) begin
			case (state_q)
				ST_KT: begin
					nl_q <= 64'sd0;
					for (int i = 0; i < 3; i++) begin
						r_q[i] <= 64'($signed(rdata_q.anchor[i])) - 64'(c_q[i]);
					end
				end
				// The spring force is added before its damping term.
				ST_DAMPT: f_q[comp_q] <= sat_add(f_q[comp_q], ctf_ext);
				default: ;
			endcase
		end
		if (state_q == ST_WRITE) begin
			for (int i = 0; i < 3; i++) begin
				fo_q[i] <= sat32(f_q[i]);
			end
		end
	end

	// Write-back word: the clearing pass writes the reset entry.
	always_comb begin
		mem_we = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
		waddr  = (state_q == ST_CLEAR) ? clr_cnt_q : addr_q;
		if (state_q == ST_CLEAR) begin
			wdata = '0;
			wdata.tag = 32'hFFFF_FFFF;
		end else begin
			wdata.tag = sub_q + 32'd1;
			if (cont) begin
				wdata.last_pen = pen_q;
				wdata.anchor   = rdata_q.anchor;
				for (int i = 0; i < 3; i++) begin
					wdata.last_tf[i] = ctf_q[i];
				end
			end else begin
				wdata.last_pen = 32'd0;
				for (int i = 0; i < 3; i++) begin
					wdata.anchor[i] = c_q[i];
				end
				wdata.last_tf = rdata_q.last_tf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	// An item that transfers makes the block busy in the next cycle.
	`PCFD_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	// Exactly one result cycle per item.
	`PCFD_ASSERT_NEXT(a_done_single, done, !done)
	// The multiplier only answers while an item is being worked on.
	`PCFD_ASSERT_SAME(a_mul_active, mrsp.done, state_q != ST_IDLE && state_q != ST_CLEAR)

endmodule
`default_nettype wire

FILE: tb/penalty_contact_force_with_damping_top_tb.sv
`default_nettype none
module penalty_contact_force_with_damping_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcfd_pkg::*;

	localparam int FRAC     = 16;
	localparam int PARTICLES = 4096;
	localparam logic signed [63:0] DAMP_FACTOR = 64'sd1311;
	localparam logic signed [63:0] LIMIT64 = 64'sh7FFF_FFFF_FFFF_FFFF;

	// One contact item, as it is put on the item ports.
	typedef struct {
		logic [31:0]        substep;
		logic [11:0]        pidx;
		logic signed [31:0] pen;
		logic signed [17:0] nrm [3];
		logic signed [31:0] pos [3];
		logic [30:0]        len;
	} contact_item_t;

	typedef struct {
		logic signed [31:0] f [3];
	} contact_force_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [31:0]        substep;
	logic [11:0]        particle_index;
	logic signed [31:0] penetration;
	logic signed [17:0] normal_x, normal_y, normal_z;
	logic signed [31:0] contact_x, contact_y, contact_z;
	logic [30:0]        particle_length;
	logic               done;
	logic signed [31:0] force_x, force_y, force_z;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [0:0]         cfg_index;
	logic [31:0]        cfg_data;

	penalty_contact_force_with_damping_top dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.substep(substep), .particle_index(particle_index), .penetration(penetration),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.contact_x(contact_x), .contact_y(contact_y), .contact_z(contact_z),
		.particle_length(particle_length),
		.done(done), .force_x(force_x), .force_y(force_y), .force_z(force_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Items waiting to be driven, and forces predicted for accepted items.
	contact_item_t  pending_contacts [$];
	contact_force_t expected_forces [$];
	contact_item_t  driven_contact;

	// Mirror of the block's registers and per-particle table.
	logic [31:0]        kn_mirror, kt_mirror;
	logic [31:0]        tag_mirror    [PARTICLES];
	logic signed [31:0] lastpen_mirror [PARTICLES];
	logic signed [31:0] anchor_mirror [PARTICLES][3];
	logic signed [31:0] tforce_mirror [PARTICLES][3];

	// Substep tag as the stimulus generator sees it, used to build continuing contacts.
	logic [31:0] next_tag [PARTICLES];

	int send_idle_pct;
	int error_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Fixed-point product: magnitude rounded half away from zero, saturated symmetric.
	function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [63:0]        ua, ub;
		logic [127:0]       p;
		logic signed [63:0] r;
		logic               neg;
		neg = (a < 0) != (b < 0);
		ua = a[63] ? (~a + 64'd1) : a;
		ub = b[63] ? (~b + 64'd1) : b;
		p = {64'd0, ua} * {64'd0, ub};
		p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
		r = (p > {64'd0, LIMIT64}) ? LIMIT64 : p[63:0];
		return neg ? -r : r;
	endfunction

	function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > $signed({1'b0, LIMIT64})) begin
			return LIMIT64;
		end else if (s < -$signed({1'b0, LIMIT64})) begin
			return -LIMIT64;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic int cmp_sign(input logic signed [63:0] a, input logic signed [63:0] b);
		return (a > b) ? 1 : ((a < b) ? -1 : 0);
	endfunction

	// Works out the force for one accepted contact and updates the table mirror.
	function automatic contact_force_t predict_contact_force(input contact_item_t it);
		contact_force_t     res;
		logic signed [63:0] f [3];
		logic signed [63:0] r [3];
		logic signed [63:0] area, fn, kt_area, nl, d, ctf;
		int                 s, ts;
		int                 idx;
		idx = it.pidx;
		area = qmul({33'd0, it.len}, {33'd0, it.len});
		fn = qmul(qmul({32'd0, kn_mirror}, area), 64'(it.pen));
		for (int i = 0; i < 3; i++) begin
			f[i] = qmul(fn, 64'(it.nrm[i]));
		end
		if (tag_mirror[idx] != it.substep) begin
			// A fresh contact records its anchor; the previous tangential force stays.
			lastpen_mirror[idx] = '0;
			for (int i = 0; i < 3; i++) begin
				anchor_mirror[idx][i] = it.pos[i];
			end
		end else begin
			s = cmp_sign(64'(it.pen), 64'(lastpen_mirror[idx]));
			kt_area = qmul({32'd0, kt_mirror}, area);
			lastpen_mirror[idx] = it.pen;
			for (int i = 0; i < 3; i++) begin
				d = qmul(f[i] < 0 ? -f[i] : f[i], DAMP_FACTOR);
				f[i] = add_clip(f[i], s > 0 ? -d : (s < 0 ? d : 64'sd0));
			end
			nl = '0;
			for (int i = 0; i < 3; i++) begin
				r[i] = 64'(anchor_mirror[idx][i]) - 64'(it.pos[i]);
				nl = add_clip(nl, qmul(r[i], 64'(it.nrm[i])));
			end
			// Spring along the anchor offset with its normal part removed, damped by its trend.
			for (int i = 0; i < 3; i++) begin
				r[i] = add_clip(r[i], -qmul(nl, 64'(it.nrm[i])));
				ctf = clip32(qmul(r[i], kt_area));
				ts = cmp_sign(ctf, 64'(tforce_mirror[idx][i]));
				tforce_mirror[idx][i] = ctf[31:0];
				d = qmul(ctf < 0 ? -ctf : ctf, DAMP_FACTOR);
				f[i] = add_clip(f[i], ctf);
				f[i] = add_clip(f[i], ts > 0 ? d : (ts < 0 ? -d : 64'sd0));
			end
		end
		tag_mirror[idx] = it.substep + 32'd1;
		for (int i = 0; i < 3; i++) begin
			res.f[i] = 32'(clip32(f[i]));
		end
		return res;
	endfunction

	// Driver: holds an item on the ports until its transfer, then predicts its force.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_forces.push_back(predict_contact_force(driven_contact));
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (pending_contacts.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
				driven_contact = pending_contacts.pop_front();
				start           <= 1'b1;
				substep         <= driven_contact.substep;
				particle_index  <= driven_contact.pidx;
				penetration     <= driven_contact.pen;
				normal_x        <= driven_contact.nrm[0];
				normal_y        <= driven_contact.nrm[1];
				normal_z        <= driven_contact.nrm[2];
				contact_x       <= driven_contact.pos[0];
				contact_y       <= driven_contact.pos[1];
				contact_z       <= driven_contact.pos[2];
				particle_length <= driven_contact.len;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result is compared with the oldest prediction.
	always @(posedge clk) begin
		contact_force_t want;
		logic signed [31:0] got [3];
		if (arst_n && done) begin
			got[0] = force_x;
			got[1] = force_y;
			got[2] = force_z;
			if (expected_forces.size() == 0) begin
				$display("%0t: force result with no prediction waiting", $realtime);
				error_count++;
			end else begin
				want = expected_forces.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (got[i] !== want.f[i]) begin
						$display("%0t: force component %0d expected %0d actual %0d",
							$realtime, i, want.f[i], got[i]);
						error_count++;
					end
				end
			end
		end
	end

	// Writes one register; the caller writes only while idle, which the block does not enforce.
	task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_NORMAL_STIFFNESS) begin
			kn_mirror = value;
		end else begin
			kt_mirror = value;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_contacts.size() > 0 || start || expected_forces.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_contact(input logic [31:0] sub, input logic [11:0] pidx,
		input logic signed [31:0] pen, input logic signed [17:0] nx,
		input logic signed [17:0] ny, input logic signed [17:0] nz,
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [31:0] pz, input logic [30:0] len);
		contact_item_t it;
		it.substep = sub;
		it.pidx = pidx;
		it.pen = pen;
		it.nrm[0] = nx;
		it.nrm[1] = ny;
		it.nrm[2] = nz;
		it.pos[0] = px;
		it.pos[1] = py;
		it.pos[2] = pz;
		it.len = len;
		next_tag[pidx] = sub + 32'd1;
		pending_contacts.push_back(it);
	endtask

	function automatic logic signed [17:0] rand_normal();
		return 18'($signed($urandom_range(131072)) - 65536);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(9) < 7) begin
			return 32'($signed($urandom_range(32'h3FFFF)) - 32'sh20000);
		end
		return $urandom;
	endfunction

	// Random contacts: mostly continuing chains on a small set of particles, so the
	// damping and tangential spring paths are reached, with fresh contacts mixed in.
	task automatic queue_random_contacts(input int count);
		logic [11:0] pidx;
		logic [31:0] sub;
		logic signed [31:0] pen;
		logic [30:0] len;
		for (int k = 0; k < count; k++) begin
			pidx = ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(47));
			if (next_tag[pidx] != 32'hFFFF_FFFF && $urandom_range(99) < 75) begin
				sub = next_tag[pidx];
			end else begin
				sub = $urandom_range(32'hFFFF_FFFE);
			end
			pen = ($urandom_range(9) < 8) ? 32'($signed($urandom_range(32'h20000)) - 32'sh10000)
				: $urandom;
			len = ($urandom_range(9) < 8) ? 31'($urandom_range(32'h30000)) : 31'($urandom);
			queue_contact(sub, pidx, pen, rand_normal(), rand_normal(), rand_normal(),
				rand_coord(), rand_coord(), rand_coord(), len);
		end
	endtask

	task automatic random_settings();
		write_register(REG_NORMAL_STIFFNESS,
			($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h80000));
		write_register(REG_TANGENT_STIFFNESS,
			($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h80000));
	endtask

	// Stimulus and end of run.
	initial begin
		send_idle_pct = 26;
		error_count = 0;
		kn_mirror = '0;
		kt_mirror = '0;
		for (int i = 0; i < PARTICLES; i++) begin
			tag_mirror[i] = '1;
			next_tag[i] = '1;
			lastpen_mirror[i] = '0;
			for (int j = 0; j < 3; j++) begin
				anchor_mirror[i][j] = '0;
				tforce_mirror[i][j] = '0;
			end
		end
		arst_n = 1'b0;
		start = 1'b0;
		substep = '0;
		particle_index = '0;
		penetration = '0;
		normal_x = '0;
		normal_y = '0;
		normal_z = '0;
		contact_x = '0;
		contact_y = '0;
		contact_z = '0;
		particle_length = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_NORMAL_STIFFNESS;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a fresh contact, then continuing contacts with rising,
		// falling and unchanged penetration, then the field extremes.
		write_register(REG_NORMAL_STIFFNESS, 32'h0001_0000);
		write_register(REG_TANGENT_STIFFNESS, 32'h0000_8000);
		queue_contact(32'd10, 12'd5, 32'sh8000, 18'sd65536, 18'sd0, 18'sd0,
			32'sh10000, 32'sh20000, -32'sh30000, 31'h10000);
		queue_contact(32'd11, 12'd5, 32'sh9000, 18'sd46341, 18'sd46341, 18'sd0,
			32'sh14000, 32'sh18000, -32'sh30000, 31'h10000);
		queue_contact(32'd12, 12'd5, 32'sh4000, 18'sd0, -18'sd65536, 18'sd0,
			32'sh16000, 32'sh18000, -32'sh2C000, 31'h10000);
		queue_contact(32'd13, 12'd5, 32'sh4000, 18'sd0, 18'sd0, -18'sd65536,
			32'sh16000, 32'sh18000, -32'sh2C000, 31'h10000);
		queue_contact(32'd0, 12'd4095, 32'sh7FFF_FFFF, -18'sd65536, 18'sd65536, 18'sd65536,
			32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
		queue_contact(32'd1, 12'd4095, -32'sh8000_0000, 18'sd65536, -18'sd65536, 18'sd65536,
			-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000, 31'h7FFF_FFFF);
		queue_contact(32'hFFFF_FFFE, 12'd0, 32'sh0, 18'sd0, 18'sd0, 18'sd0,
			32'sh0, 32'sh0, 32'sh0, 31'h0);
		queue_contact(32'h5555_5555, 12'd2730, -32'sh1, 18'sd1, -18'sd1, 18'sd1,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA);
		queue_contact(32'h5555_5556, 12'd2730, -32'sh1, 18'sd1, -18'sd1, 18'sd1,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555);
		wait_drained();
		write_register(REG_NORMAL_STIFFNESS, 32'hFFFF_FFFF);
		write_register(REG_TANGENT_STIFFNESS, 32'hFFFF_FFFF);
		queue_contact(32'd100, 12'd7, 32'sh20000, 18'sd65536, 18'sd0, 18'sd0,
			32'sh0, 32'sh0, 32'sh0, 31'h20000);
		queue_contact(32'd101, 12'd7, 32'sh10000, 18'sd0, 18'sd65536, 18'sd0,
			-32'sh40000, 32'sh50000, 32'sh7000, 31'h20000);
		queue_contact(32'd102, 12'd7, -32'sh8000_0000, 18'sd0, 18'sd0, 18'sd65536,
			32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
		queue_contact(32'd103, 12'd7, 32'sh1000, 18'sd65536, 18'sd0, 18'sd0,
			32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF, 31'h100);
		wait_drained();
		write_register(REG_NORMAL_STIFFNESS, 32'h0);
		write_register(REG_TANGENT_STIFFNESS, 32'h0);
		queue_contact(32'd104, 12'd7, 32'sh5000, 18'sd65536, 18'sd0, 18'sd0,
			32'sh100, 32'sh200, 32'sh300, 31'h18000);
		queue_contact(32'd105, 12'd7, 32'sh4000, 18'sd65536, 18'sd0, 18'sd0,
			32'sh100, 32'sh200, 32'sh300, 31'h18000);
		wait_drained();

		// Random part in three idling regimes, each with its own register setting.
		random_settings();
		queue_random_contacts(580);
		wait_drained();
		send_idle_pct = 57;
		random_settings();
		queue_random_contacts(580);
		wait_drained();
		send_idle_pct = 0;
		random_settings();
		queue_random_contacts(580);
		wait_drained();

		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Run limit, many times the slowest correct run.
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/pcfd_pkg.sv
src/pcfd_mulq.sv
src/penalty_contact_force_with_damping_top.sv
tb/penalty_contact_force_with_damping_top_tb.sv
